// ===== rtl/foc_park_clarke_svm_transform_unit_defines.svh =====
// Assertion macros shared by the checker of the transform unit.
`ifndef FOC_PARK_CLARKE_SVM_TRANSFORM_UNIT_DEFINES_SVH
`define FOC_PARK_CLARKE_SVM_TRANSFORM_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk and quiet during reset.
`define FPCS_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("fpcs assertion failed");

// Next-cycle implication, sampled on clk and quiet during reset.
`define FPCS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("fpcs assertion failed");

`endif

// ===== rtl/fpcs_pkg.sv =====
// Types, constants and helper functions of the FOC transform pipeline.
package fpcs_pkg;

  typedef logic signed [15:0] q15_t;
  typedef logic signed [17:0] o18_t;
  typedef logic signed [39:0] acc_t;

  // Pipeline depth of the whole unit and of the sine/cosine part.
  localparam int PIPE_DEPTH = 14;
  localparam int SC_DEPTH   = 8;

  // Q15 constants.
  localparam q15_t Q15_INV_SQRT3  = 16'sd18919;
  localparam q15_t Q15_SQRT3_HALF = 16'sd28378;

  localparam logic [14:0] QUARTER_TURN = 15'd16384;

  // Q30 coefficients of the odd quadrant sine polynomial.
  localparam logic [31:0] POLY_C9 = 32'd172272;
  localparam logic [31:0] POLY_C7 = 32'd5026995;
  localparam logic [31:0] POLY_C5 = 32'd85569306;
  localparam logic [31:0] POLY_C3 = 32'd693598669;
  localparam logic [31:0] POLY_C1 = 32'd1686629713;

  // Coefficients in Horner order after the leading one.
  function automatic logic [31:0] poly_coef(input int step);
    logic [31:0] c;
    case (step)
      0:       c = POLY_C7;
      1:       c = POLY_C5;
      2:       c = POLY_C3;
      default: c = POLY_C1;
    endcase
    return c;
  endfunction

  // Round half up from Q30 products to Q15, kept to 18 bits.
  function automatic o18_t round15(input acc_t x);
    acc_t t;
    t = (x + 40'sd16384) >>> 15;
    return t[17:0];
  endfunction

endpackage

// ===== rtl/fpcs_if.sv =====
// Request channels of the transform unit: input items and result items.
interface fpcs_in_if;
  import fpcs_pkg::*;
  logic valid;
  logic ready;
  q15_t phase_a_current;
  q15_t phase_b_current;
  logic [15:0] rotor_angle;
  q15_t d_voltage_cmd;
  q15_t q_voltage_cmd;

  modport source (output valid, phase_a_current, phase_b_current, rotor_angle,
                  d_voltage_cmd, q_voltage_cmd, input ready);
  modport sink (input valid, phase_a_current, phase_b_current, rotor_angle,
                d_voltage_cmd, q_voltage_cmd, output ready);
endinterface

interface fpcs_out_if;
  import fpcs_pkg::*;
  logic valid;
  logic ready;
  o18_t d_current;
  o18_t q_current;
  o18_t common_offset;
  o18_t duty_a;
  o18_t duty_b;
  o18_t duty_c;

  modport source (output valid, d_current, q_current, common_offset, duty_a, duty_b,
                  duty_c, input ready);
  modport sink (input valid, d_current, q_current, common_offset, duty_a, duty_b,
                duty_c, output ready);
endinterface

// ===== rtl/fpcs_sincos.sv =====
// Pipelined sine and cosine of the truncated rotor angle by a quadrant polynomial.
module fpcs_sincos #(
  parameter int SINE_TABLE_BITS = 10
) (
  input  logic                  clk,
  input  logic [fpcs_pkg::SC_DEPTH:1] en,
  input  logic [15:0]           angle,
  output fpcs_pkg::q15_t        sin_o,
  output fpcs_pkg::q15_t        cos_o
);
  import fpcs_pkg::*;

  localparam int DROP = 16 - SINE_TABLE_BITS;

  logic [15:0] a_trunc;
  logic [14:0] r_in;

  // Lane 0 evaluates sin(r), lane 1 evaluates sin(quarter - r).
  logic [14:0] t_r [1:6][2];
  logic [30:0] u_r [2:5][2];
  logic [1:0]  q_r [1:7];
  logic [31:0] p_r [3:6][2];
  logic [31:0] v_r [2];
  q15_t        sin_r, cos_r;

  assign a_trunc = angle & ~((16'(1) << DROP) - 16'(1));
  assign r_in    = {1'b0, a_trunc[13:0]};

  // Stage 1: split the angle into quadrant and remainder.
  always_ff @(posedge clk) begin
    if (en[1]) begin
      t_r[1][0] <= r_in;
      t_r[1][1] <= QUARTER_TURN - r_in;
      q_r[1]    <= a_trunc[15:14];
    end
  end

  // Stage 2: square of the remainder, times four.
  for (genvar l = 0; l < 2; l++) begin : g_sq
    logic [29:0] sq;
    assign sq = 30'(t_r[1][l]) * 30'(t_r[1][l]);
    always_ff @(posedge clk) begin
      if (en[2]) begin
        t_r[2][l] <= t_r[1][l];
        u_r[2][l] <= {sq, 1'b0} << 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      q_r[2] <= q_r[1];
    end
  end

  // Stages 3 to 6: one Horner step each.
  for (genvar h = 3; h <= 6; h++) begin : g_horner
    for (genvar l = 0; l < 2; l++) begin : g_lane
      logic [31:0] prev;
      logic [63:0] prod;
      if (h == 3) begin : g_first
        assign prev = POLY_C9;
      end else begin : g_rest
        assign prev = p_r[h-1][l];
      end
      assign prod = 64'(prev) * 64'(u_r[h-1][l]);
      always_ff @(posedge clk) begin
        if (en[h]) begin
          p_r[h][l] <= poly_coef(h - 3) - prod[61:30];
          t_r[h][l] <= t_r[h-1][l];
        end
      end
      // The squared remainder is only needed up to the last Horner step.
      if (h < 6) begin : g_u
        always_ff @(posedge clk) begin
          if (en[h]) begin
            u_r[h][l] <= u_r[h-1][l];
          end
        end
      end
    end
    always_ff @(posedge clk) begin
      if (en[h]) begin
        q_r[h] <= q_r[h-1];
      end
    end
  end

  // Stage 7: final product by the remainder.
  for (genvar l = 0; l < 2; l++) begin : g_fin
    logic [46:0] prod;
    assign prod = 47'(p_r[6][l]) * 47'(t_r[6][l]);
    always_ff @(posedge clk) begin
      if (en[7]) begin
        v_r[l] <= prod[45:14];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[7]) begin
      q_r[7] <= q_r[6];
    end
  end

  // Stage 8: round to Q15, saturate, and map to the quadrant.
  logic [32:0] rnd [2];
  q15_t        mag [2];
  for (genvar l = 0; l < 2; l++) begin : g_rnd
    logic [17:0] qv;
    assign rnd[l] = 33'(v_r[l]) + 33'd16384;
    assign qv     = rnd[l][32:15] > 18'd32767 ? 18'd32767 : rnd[l][32:15];
    assign mag[l] = qv[15:0];
  end

  always_ff @(posedge clk) begin
    if (en[8]) begin
      case (q_r[7])
        2'd0: begin
          sin_r <= mag[0];
          cos_r <= mag[1];
        end
        2'd1: begin
          sin_r <= mag[1];
          cos_r <= -mag[0];
        end
        2'd2: begin
          sin_r <= -mag[0];
          cos_r <= -mag[1];
        end
        default: begin
          sin_r <= -mag[1];
          cos_r <= mag[0];
        end
      endcase
    end
  end

  assign sin_o = sin_r;
  assign cos_o = cos_r;

endmodule

// ===== rtl/fpcs_xform.sv =====
// Clarke, Park, inverse transforms and min-max offset injection, pipelined.
module fpcs_xform (
  input  logic                          clk,
  input  logic [fpcs_pkg::PIPE_DEPTH:1] en,
  input  fpcs_pkg::q15_t                ia,
  input  fpcs_pkg::q15_t                ib,
  input  fpcs_pkg::q15_t                vd,
  input  fpcs_pkg::q15_t                vq,
  input  fpcs_pkg::q15_t                sin_i,
  input  fpcs_pkg::q15_t                cos_i,
  input  logic [15:0]                   bus_voltage,
  output fpcs_pkg::o18_t                d_current,
  output fpcs_pkg::o18_t                q_current,
  output fpcs_pkg::o18_t                common_offset,
  output fpcs_pkg::o18_t                duty_a,
  output fpcs_pkg::o18_t                duty_b,
  output fpcs_pkg::o18_t                duty_c
);
  import fpcs_pkg::*;

  // Stage 1: Clarke beta product.
  logic signed [17:0] ab_sum;
  acc_t               bprod_r;
  q15_t               ia_r [1:8];
  q15_t               vd_r [1:8];
  q15_t               vq_r [1:8];
  o18_t               beta_r [2:8];

  assign ab_sum = 18'(ia) + (18'(ib) <<< 1);

  always_ff @(posedge clk) begin
    if (en[1]) begin
      bprod_r  <= 40'(ab_sum) * 40'(Q15_INV_SQRT3);
      ia_r[1]  <= ia;
      vd_r[1]  <= vd;
      vq_r[1]  <= vq;
    end
  end

  // Stages 2 to 8: round beta, then wait for sine and cosine.
  always_ff @(posedge clk) begin
    if (en[2]) begin
      beta_r[2] <= round15(bprod_r);
    end
  end

  for (genvar k = 2; k <= 8; k++) begin : g_dly
    always_ff @(posedge clk) begin
      if (en[k]) begin
        ia_r[k] <= ia_r[k-1];
        vd_r[k] <= vd_r[k-1];
        vq_r[k] <= vq_r[k-1];
      end
    end
    if (k > 2) begin : g_beta
      always_ff @(posedge clk) begin
        if (en[k]) begin
          beta_r[k] <= beta_r[k-1];
        end
      end
    end
  end

  // Stage 9: all rotation products.
  acc_t p_ac_r, p_bs_r, p_bc_r, p_as_r, p_dc_r, p_qs_r, p_ds_r, p_qc_r;

  always_ff @(posedge clk) begin
    if (en[9]) begin
      p_ac_r <= 40'(ia_r[8]) * 40'(cos_i);
      p_bs_r <= 40'(beta_r[8]) * 40'(sin_i);
      p_bc_r <= 40'(beta_r[8]) * 40'(cos_i);
      p_as_r <= 40'(ia_r[8]) * 40'(sin_i);
      p_dc_r <= 40'(vd_r[8]) * 40'(cos_i);
      p_qs_r <= 40'(vq_r[8]) * 40'(sin_i);
      p_ds_r <= 40'(vd_r[8]) * 40'(sin_i);
      p_qc_r <= 40'(vq_r[8]) * 40'(cos_i);
    end
  end

  // Stage 10: Park currents and inverse Park voltages.
  o18_t id_r [10:14];
  o18_t iq_r [10:14];
  o18_t valpha_r, vbeta_r;

  always_ff @(posedge clk) begin
    if (en[10]) begin
      id_r[10] <= round15(p_ac_r + p_bs_r);
      iq_r[10] <= round15(p_bc_r - p_as_r);
      valpha_r <= round15(p_dc_r - p_qs_r);
      vbeta_r  <= round15(p_ds_r + p_qc_r);
    end
  end

  for (genvar k = 11; k <= 14; k++) begin : g_idq
    always_ff @(posedge clk) begin
      if (en[k]) begin
        id_r[k] <= id_r[k-1];
        iq_r[k] <= iq_r[k-1];
      end
    end
  end

  // Stage 11: inverse Clarke products.
  acc_t half_a, s3_b;
  acc_t vb_sum_r, vc_sum_r;
  o18_t va_r [11:13];

  assign half_a = 40'(valpha_r) <<< 14;
  assign s3_b   = 40'(vbeta_r) * 40'(Q15_SQRT3_HALF);

  always_ff @(posedge clk) begin
    if (en[11]) begin
      vb_sum_r  <= s3_b - half_a;
      vc_sum_r  <= -half_a - s3_b;
      va_r[11]  <= valpha_r;
    end
  end

  // Stage 12: round phase B and C voltages.
  o18_t vb_r [12:13];
  o18_t vc_r [12:13];

  always_ff @(posedge clk) begin
    if (en[12]) begin
      vb_r[12] <= round15(vb_sum_r);
      vc_r[12] <= round15(vc_sum_r);
      va_r[12] <= va_r[11];
    end
  end

  // Stage 13: min-max common-mode offset.
  o18_t               hi, lo;
  logic signed [18:0] hl_sum;
  o18_t               vk_r [13:14];

  always_comb begin
    hi = va_r[12];
    lo = va_r[12];
    if (vb_r[12] > hi) hi = vb_r[12];
    if (vc_r[12] > hi) hi = vc_r[12];
    if (vb_r[12] < lo) lo = vb_r[12];
    if (vc_r[12] < lo) lo = vc_r[12];
  end

  assign hl_sum = 19'(hi) + 19'(lo);

  always_ff @(posedge clk) begin
    if (en[13]) begin
      vk_r[13] <= hl_sum[18:1];
      va_r[13] <= va_r[12];
      vb_r[13] <= vb_r[12];
      vc_r[13] <= vc_r[12];
    end
  end

  // Stage 14: duty voltages centered on half the bus.
  o18_t half_bus;
  o18_t da_r, db_r, dc_r;

  assign half_bus = {3'b000, bus_voltage[15:1]};

  always_ff @(posedge clk) begin
    if (en[14]) begin
      vk_r[14] <= vk_r[13];
      da_r     <= va_r[13] - vk_r[13] + half_bus;
      db_r     <= vb_r[13] - vk_r[13] + half_bus;
      dc_r     <= vc_r[13] - vk_r[13] + half_bus;
    end
  end

  assign d_current     = id_r[14];
  assign q_current     = iq_r[14];
  assign common_offset = vk_r[14];
  assign duty_a        = da_r;
  assign duty_b        = db_r;
  assign duty_c        = dc_r;

endmodule

// ===== rtl/foc_park_clarke_svm_transform_unit.sv =====
// Top level of the FOC Clarke/Park/inverse-Park/SVM transform pipeline.
// One request enters per clock unless output back-pressure holds the pipeline:
// eight stages build sine and cosine from a Horner polynomial, six more run the
// rotations, the inverse Clarke step and the offset injection. Each stage holds
// its own valid bit and only stalls when it is full and the stage after it
// stalls, so bubbles close up under output back-pressure and the pipeline holds
// up to 14 requests. bus_voltage is read at the last stage and should be
// written only while no request is in flight.
module foc_park_clarke_svm_transform_unit #(
  parameter int SINE_TABLE_BITS = 10
) (
  input  logic        clk,
  input  logic        rst_n,
  fpcs_in_if.sink     in_ch,
  fpcs_out_if.source  out_ch,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata
);
  import fpcs_pkg::*;

  logic [15:0]           bus_r;
  logic [PIPE_DEPTH:1]   vld_r;
  logic [PIPE_DEPTH:1]   vld_nxt;
  logic [PIPE_DEPTH+1:1] rdy;
  q15_t                  sin_w, cos_w;

  // Bus voltage register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bus_r <= '0;
    end else if (cfg_we) begin
      bus_r <= cfg_wdata;
    end
  end

  // A stage may load when it is empty or the next stage moves on.
  always_comb begin
    rdy[PIPE_DEPTH+1] = out_ch.ready;
    for (int k = PIPE_DEPTH; k >= 1; k--) begin
      rdy[k] = !vld_r[k] || rdy[k+1];
    end
    vld_nxt[1] = rdy[1] ? in_ch.valid : vld_r[1];
    for (int k = 2; k <= PIPE_DEPTH; k++) begin
      if (rdy[k]) begin
        vld_nxt[k] = vld_r[k-1];
      end else begin
        vld_nxt[k] = vld_r[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_ch.ready  = rdy[1];
  assign out_ch.valid = vld_r[PIPE_DEPTH];

  fpcs_sincos #(
    .SINE_TABLE_BITS(SINE_TABLE_BITS)
  ) u_sincos (
    .clk   (clk),
    .en    (rdy[SC_DEPTH:1]),
    .angle (in_ch.rotor_angle),
    .sin_o (sin_w),
    .cos_o (cos_w)
  );

  fpcs_xform u_xform (
    .clk           (clk),
    .en            (rdy[PIPE_DEPTH:1]),
    .ia            (in_ch.phase_a_current),
    .ib            (in_ch.phase_b_current),
    .vd            (in_ch.d_voltage_cmd),
    .vq            (in_ch.q_voltage_cmd),
    .sin_i         (sin_w),
    .cos_i         (cos_w),
    .bus_voltage   (bus_r),
    .d_current     (out_ch.d_current),
    .q_current     (out_ch.q_current),
    .common_offset (out_ch.common_offset),
    .duty_a        (out_ch.duty_a),
    .duty_b        (out_ch.duty_b),
    .duty_c        (out_ch.duty_c)
  );

endmodule

// ===== rtl/fpcs_checker.sv =====
// Port-level checker of the transform unit and its bind.
`include "foc_park_clarke_svm_transform_unit_defines.svh"

module fpcs_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input fpcs_pkg::o18_t       out_d_current,
  input fpcs_pkg::o18_t       out_duty_a
);
  import fpcs_pkg::*;

  logic [4:0] cnt_r;
  logic [4:0] cnt_nxt;

  // Requests accepted but not yet delivered.
  always_comb begin
    cnt_nxt = cnt_r;
    if (in_valid && in_ready) cnt_nxt = cnt_nxt + 5'd1;
    if (out_valid && out_ready) cnt_nxt = cnt_nxt - 5'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  // A stalled result keeps its valid, d_current and duty_a.
  `FPCS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
    out_valid && $stable(out_d_current) && $stable(out_duty_a))
  // Input back-pressure only comes from a stalled output.
  `FPCS_ASSERT_IMPL(a_in_stall, !in_ready, out_valid && !out_ready)
  // No result without an accepted request behind it.
  `FPCS_ASSERT_IMPL(a_no_invent, out_valid, cnt_r != 5'd0)
  // In-flight requests never exceed the pipeline depth.
  `FPCS_ASSERT_IMPL(a_depth, 1'b1, cnt_r <= 5'(PIPE_DEPTH))

endmodule

bind foc_park_clarke_svm_transform_unit fpcs_checker u_fpcs_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_d_current (out_ch.d_current),
  .out_duty_a    (out_ch.duty_a)
);

// ===== dv/foc_park_clarke_svm_transform_unit_test.sv =====
// Self-checking testbench for the FOC Clarke/Park/SVM transform unit.
`timescale 1ns / 1ps

module foc_park_clarke_svm_transform_unit_test;
  import fpcs_pkg::*;

  localparam int TABLE_BITS = 10;

  // One expected result of the transform unit.
  typedef struct packed {
    logic [17:0] d_current;
    logic [17:0] q_current;
    logic [17:0] common_offset;
    logic [17:0] duty_a;
    logic [17:0] duty_b;
    logic [17:0] duty_c;
  } foc_result_t;

  // Tracks pending transform results and compares them with the unit's output.
  class foc_scoreboard;
    foc_result_t pending[$];
    int errors;
    logic [15:0] bus_voltage;

    function new();
      errors = 0;
      bus_voltage = 16'd0;
    endfunction

    // Floor division by 2^15 after adding half, as the unit rounds.
    function longint rnd15(longint x);
      return (x + 16384) >>> 15;
    endfunction

    // Quadrant sine from the odd ninth-order polynomial, Q15, saturated.
    function longint quadrant_sine(int unsigned r);
      logic [63:0] t, u, p, v;
      t = r;
      u = (t * t) << 2;
      p = 64'd172272;
      p = 64'd5026995 - ((p * u) >> 30);
      p = 64'd85569306 - ((p * u) >> 30);
      p = 64'd693598669 - ((p * u) >> 30);
      p = 64'd1686629713 - ((p * u) >> 30);
      v = (p * t) >> 14;
      v = (v + 64'd16384) >> 15;
      if (v > 64'd32767) v = 64'd32767;
      return longint'(v);
    endfunction

    // Notes an accepted request and queues the result it should produce.
    function void note_request(logic signed [15:0] ia, logic signed [15:0] ib,
                               logic [15:0] ang, logic signed [15:0] vd,
                               logic signed [15:0] vq);
      logic [15:0] a;
      longint sr, cr, s, c, beta, id, iq, valpha, vbeta, va, vb, vc, hi, lo, vk, hb;
      foc_result_t r;
      a = (ang >> (16 - TABLE_BITS)) << (16 - TABLE_BITS);
      sr = quadrant_sine(a[13:0]);
      cr = quadrant_sine(16384 - a[13:0]);
      case (a[15:14])
        2'd0: begin s = sr;  c = cr;  end
        2'd1: begin s = cr;  c = -sr; end
        2'd2: begin s = -sr; c = -cr; end
        default: begin s = -cr; c = sr; end
      endcase
      beta = rnd15((longint'(ia) + 2 * longint'(ib)) * 18919);
      id = rnd15(ia * c + beta * s);
      iq = rnd15(beta * c - ia * s);
      valpha = rnd15(vd * c - vq * s);
      vbeta = rnd15(vd * s + vq * c);
      va = valpha;
      vb = rnd15(-valpha * 16384 + vbeta * 28378);
      vc = rnd15(-valpha * 16384 - vbeta * 28378);
      hi = va; lo = va;
      if (vb > hi) hi = vb;
      if (vc > hi) hi = vc;
      if (vb < lo) lo = vb;
      if (vc < lo) lo = vc;
      vk = (hi + lo) >>> 1;
      hb = bus_voltage >> 1;
      r.d_current = id[17:0];
      r.q_current = iq[17:0];
      r.common_offset = vk[17:0];
      r.duty_a = 18'(va - vk + hb);
      r.duty_b = 18'(vb - vk + hb);
      r.duty_c = 18'(vc - vk + hb);
      pending.push_back(r);
    endfunction

    // Compares an accepted result with the oldest expectation.
    function void check_result(foc_result_t got);
      foc_result_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (want.d_current !== got.d_current)
        $display("%0t: d_current expected %h actual %h", $time, want.d_current,
                 got.d_current);
      if (want.q_current !== got.q_current)
        $display("%0t: q_current expected %h actual %h", $time, want.q_current,
                 got.q_current);
      if (want.common_offset !== got.common_offset)
        $display("%0t: common_offset expected %h actual %h", $time,
                 want.common_offset, got.common_offset);
      if (want.duty_a !== got.duty_a)
        $display("%0t: duty_a expected %h actual %h", $time, want.duty_a, got.duty_a);
      if (want.duty_b !== got.duty_b)
        $display("%0t: duty_b expected %h actual %h", $time, want.duty_b, got.duty_b);
      if (want.duty_c !== got.duty_c)
        $display("%0t: duty_c expected %h actual %h", $time, want.duty_c, got.duty_c);
      if (want !== got) errors++;
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [15:0] cfg_wdata;
  int send_idle_pct;
  int recv_idle_pct;
  foc_scoreboard board;

  fpcs_in_if in_ch ();
  fpcs_out_if out_ch ();

  foc_park_clarke_svm_transform_unit #(.SINE_TABLE_BITS(TABLE_BITS)) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch.sink),
    .out_ch   (out_ch.source),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  // 4 ns clock.
  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Result side: random stalls, sampling at the rising edge.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready)
        board.check_result({out_ch.d_current, out_ch.q_current, out_ch.common_offset,
                            out_ch.duty_a, out_ch.duty_b, out_ch.duty_c});
      @(negedge clk);
      out_ch.ready = ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Sends one request, with a random gap first, and waits for acceptance.
  task automatic send_request(logic [15:0] ia, logic [15:0] ib, logic [15:0] ang,
                              logic [15:0] vd, logic [15:0] vq);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid = 1'b1;
    in_ch.phase_a_current = ia;
    in_ch.phase_b_current = ib;
    in_ch.rotor_angle = ang;
    in_ch.d_voltage_cmd = vd;
    in_ch.q_voltage_cmd = vq;
    do @(posedge clk); while (!in_ch.ready);
    board.note_request(ia, ib, ang, vd, vq);
    @(negedge clk);
    in_ch.valid = 1'b0;
  endtask

  // Waits until every expected result has come, then for the pipeline to drain.
  task automatic drain_pipeline();
    in_ch.valid = 1'b0;
    while (board.pending.size() != 0) @(negedge clk);
    repeat (PIPE_DEPTH + 4) @(negedge clk);
  endtask

  // Writes the bus voltage register while the unit is idle.
  task automatic write_bus_voltage(logic [15:0] v);
    drain_pipeline();
    cfg_we = 1'b1;
    cfg_wdata = v;
    @(negedge clk);
    cfg_we = 1'b0;
    board.bus_voltage = v;
  endtask

  // Random request with occasional extreme field values.
  function automatic logic [15:0] pick_field();
    case ($urandom_range(7))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3: return 16'hffff;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic random_phase(int count, int s_pct, int r_pct);
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    repeat (count)
      send_request(pick_field(), pick_field(), 16'($urandom), pick_field(), pick_field());
  endtask

  // Main stimulus.
  initial begin
    logic [15:0] angles[8] = '{16'h0000, 16'h4000, 16'h8000, 16'hc000,
                               16'h003f, 16'h3fff, 16'hffff, 16'h2000};
    board = new();
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = 16'd0;
    in_ch.valid = 1'b0;
    in_ch.phase_a_current = '0;
    in_ch.phase_b_current = '0;
    in_ch.rotor_angle = '0;
    in_ch.d_voltage_cmd = '0;
    in_ch.q_voltage_cmd = '0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    // Directed: quadrant boundaries, truncated angle bits, field extremes.
    foreach (angles[i])
      send_request(16'h7fff, 16'h8000, angles[i], 16'h8000, 16'h7fff);
    send_request(16'h8000, 16'h8000, 16'h1234, 16'h8000, 16'h8000);
    send_request(16'h7fff, 16'h7fff, 16'h9abc, 16'h7fff, 16'h7fff);
    send_request(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_request(16'h0001, 16'hffff, 16'h5555, 16'h0001, 16'hffff);
    write_bus_voltage(16'hffff);
    send_request(16'h8000, 16'h7fff, 16'h6000, 16'h7fff, 16'h8000);
    send_request(16'h4000, 16'hc000, 16'he000, 16'h0003, 16'hfffd);
    write_bus_voltage(16'd1);
    send_request(16'h0000, 16'h0000, 16'h0000, 16'h0001, 16'h0000);
    send_request(16'h7fff, 16'h8000, 16'ha000, 16'h7fff, 16'h7fff);

    // Random phases: receiver idles, then sender idles, then neither.
    write_bus_voltage(16'd24000);
    random_phase(450, 35, 86);
    // Hold off until everything has come back, then change the bus voltage.
    write_bus_voltage(16'($urandom));
    random_phase(450, 86, 35);
    write_bus_voltage(16'd0);
    random_phase(450, 0, 0);
    drain_pipeline();

    if (board.errors == 0 && board.pending.size() == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

  // Watchdog.
  initial begin
    #2000000;
    $display("CHECKS FAILED");
    $finish;
  end
endmodule

// ===== files.f =====
+incdir+rtl
rtl/fpcs_pkg.sv
rtl/fpcs_if.sv
rtl/fpcs_sincos.sv
rtl/fpcs_xform.sv
rtl/foc_park_clarke_svm_transform_unit.sv
rtl/fpcs_checker.sv
dv/foc_park_clarke_svm_transform_unit_test.sv
